FILE: sv/jpeg_marker_segment_scanner_core_assert.svh
// Assertion macros used by the scanner checker.
`ifndef JPEG_MARKER_SEGMENT_SCANNER_CORE_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define JMSS_ASSERT_SAME(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define JMSS_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define JMSS_ASSERT_NEXT_ALWAYS(label, cond, prop, msg) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: sv/jmss_pkg.sv
// Types and constants of the JPEG marker segment scanner.
package jmss_pkg;

   localparam logic [7:0] PREFIX_BYTE   = 8'hFF;
   localparam logic [7:0] SOS_CODE      = 8'hDA;
   localparam logic [7:0] EOI_CODE      = 8'hD9;
   localparam logic [7:0] STANDALONE_LO = 8'((12 * 16) + 16);
   localparam logic [7:0] STANDALONE_HI = 8'((12 * 16) + 25);
   localparam logic [7:0] MARKER_LO     = 8'hC0;

   localparam int unsigned REPORT_WIDTH = 32;

   typedef enum logic [1:0] {
      EV_SEGMENT = 2'd0,
      EV_SCAN    = 2'd1,
      EV_EOI     = 2'd2,
      EV_DESYNC  = 2'd3
   } event_kind_type;

   typedef enum logic [6:0] {
      ST_SEEK    = 7'b0000001,
      ST_PREFIX  = 7'b0000010,
      ST_LEN_HI  = 7'b0000100,
      ST_LEN_LO  = 7'b0001000,
      ST_SKIP    = 7'b0010000,
      ST_SCAN    = 7'b0100000,
      ST_SCAN_FF = 7'b1000000
   } parse_state_type;

   typedef struct packed {
      logic                      hit;
      event_kind_type            kind;
      logic [7:0]                code;
      logic [REPORT_WIDTH-1:0]   offset;
   } event_type;

endpackage

FILE: sv/jmss_if.sv
// Handshake channels of the scanner: byte input and event output.
interface jmss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface jmss_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  marker_code;
   logic [31:0] byte_offset;

   modport source (output valid, output event_kind, output marker_code,
                   output byte_offset, input ready);
   modport sink   (input valid, input event_kind, input marker_code,
                   input byte_offset, output ready);
endinterface

FILE: sv/jmss_fsm.sv
// Marker parse state machine, length skip counter and byte offset counter.
module jmss_fsm #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   output jmss_pkg::event_type event_out
);

   jmss_pkg::parse_state_type state_ff, state_in;
   logic [7:0]              length_high_ff, length_high_in;
   logic [15:0]             skip_ff, skip_in;
   logic [OFFSET_WIDTH-1:0] count_ff, count_in;
   logic                    desync_ff, desync_in;

   logic [OFFSET_WIDTH-1:0] count_next;
   logic [63:0]             pos_wide, next_wide;
   logic [31:0]             pos_sat, next_sat;
   logic                    standalone, is_marker;
   logic [15:0]             seg_len, skip_load, skip_dec;

   assign count_next = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
   assign pos_wide   = 64'(count_ff);
   assign next_wide  = 64'(count_next);
   assign pos_sat    = (|pos_wide[63:32])  ? '1 : pos_wide[31:0];
   assign next_sat   = (|next_wide[63:32]) ? '1 : next_wide[31:0];

   assign standalone = (data_byte >= jmss_pkg::STANDALONE_LO) &&
                       (data_byte <= jmss_pkg::STANDALONE_HI);
   assign is_marker  = (data_byte >= jmss_pkg::MARKER_LO) && !standalone &&
                       (data_byte != jmss_pkg::PREFIX_BYTE);

   assign seg_len   = {length_high_ff, data_byte};
   assign skip_load = (seg_len >= 16'd2) ? seg_len - 16'd2 : '0;
   assign skip_dec  = (skip_ff != '0) ? skip_ff - 16'd1 : '0;

   always_comb begin
      state_in       = state_ff;
      length_high_in = length_high_ff;
      skip_in        = skip_ff;
      count_in       = count_ff;
      desync_in      = desync_ff;
      event_out      = '{hit: 1'b0, kind: jmss_pkg::EV_SEGMENT,
                         code: data_byte, offset: pos_sat};
      if (fire) begin
         count_in = count_next;
         unique case (state_ff)
            jmss_pkg::ST_SEEK: begin
               if (data_byte == jmss_pkg::PREFIX_BYTE) begin
                  desync_in = 1'b0;
                  state_in  = jmss_pkg::ST_PREFIX;
               end else if (!desync_ff) begin
                  desync_in      = 1'b1;
                  event_out.hit  = 1'b1;
                  event_out.kind = jmss_pkg::EV_DESYNC;
               end
            end
            jmss_pkg::ST_PREFIX: begin
               if (data_byte == jmss_pkg::PREFIX_BYTE) begin
                  state_in = jmss_pkg::ST_PREFIX;
               end else if (standalone) begin
                  state_in = jmss_pkg::ST_SEEK;
               end else if (is_marker) begin
                  event_out.hit = 1'b1;
                  if (data_byte == jmss_pkg::SOS_CODE) begin
                     state_in       = jmss_pkg::ST_SCAN;
                     event_out.kind = jmss_pkg::EV_SCAN;
                  end else begin
                     state_in = jmss_pkg::ST_LEN_HI;
                  end
               end else begin
                  desync_in      = 1'b1;
                  state_in       = jmss_pkg::ST_SEEK;
                  event_out.hit  = 1'b1;
                  event_out.kind = jmss_pkg::EV_DESYNC;
               end
            end
            jmss_pkg::ST_LEN_HI: begin
               length_high_in = data_byte;
               state_in       = jmss_pkg::ST_LEN_LO;
            end
            jmss_pkg::ST_LEN_LO: begin
               skip_in  = skip_load;
               state_in = (skip_load != '0) ? jmss_pkg::ST_SKIP : jmss_pkg::ST_SEEK;
            end
            jmss_pkg::ST_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  state_in = jmss_pkg::ST_SEEK;
               end
            end
            jmss_pkg::ST_SCAN: begin
               if (data_byte == jmss_pkg::PREFIX_BYTE) begin
                  state_in = jmss_pkg::ST_SCAN_FF;
               end
            end
            jmss_pkg::ST_SCAN_FF: begin
               if (data_byte == jmss_pkg::PREFIX_BYTE) begin
                  state_in = jmss_pkg::ST_SCAN_FF;
               end else if (data_byte == jmss_pkg::EOI_CODE) begin
                  // end of image reports the running byte count
                  state_in         = jmss_pkg::ST_SEEK;
                  event_out.hit    = 1'b1;
                  event_out.kind   = jmss_pkg::EV_EOI;
                  event_out.offset = next_sat;
               end else if (is_marker) begin
                  event_out.hit = 1'b1;
                  if (data_byte == jmss_pkg::SOS_CODE) begin
                     state_in       = jmss_pkg::ST_SCAN;
                     event_out.kind = jmss_pkg::EV_SCAN;
                  end else begin
                     state_in = jmss_pkg::ST_LEN_HI;
                  end
               end else begin
                  // stuffed zero, restart or stray byte: stay in scan data
                  state_in = jmss_pkg::ST_SCAN;
               end
            end
            default: begin
               state_in = jmss_pkg::ST_SEEK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= jmss_pkg::ST_SEEK;
         length_high_ff <= '0;
         skip_ff        <= '0;
         count_ff       <= '0;
         desync_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         length_high_ff <= length_high_in;
         skip_ff        <= skip_in;
         count_ff       <= count_in;
         desync_ff      <= desync_in;
      end
   end

endmodule

FILE: sv/jmss_out_reg.sv
// Result register: holds one event until the sink takes it.
module jmss_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jmss_pkg::event_type event_in,
   input  logic                take,
   output logic                valid,
   output jmss_pkg::event_type event_q
);

   logic                valid_ff, valid_in;
   jmss_pkg::event_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff && !take;
      data_in  = data_ff;
      if (load && event_in.hit) begin
         valid_in = 1'b1;
         data_in  = event_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid   = valid_ff;
   assign event_q = data_ff;

endmodule

FILE: sv/jpeg_marker_segment_scanner_core.sv
// Top level of the JPEG marker segment scanner.
//
//   channel   dir  payload                                   accepted when
//   req_if    in   data_byte[7:0]                            valid && ready
//   rsp_if    out  event_kind[1:0] marker_code[7:0]          valid && ready
//                  byte_offset[31:0]
//
// One byte a cycle while no event is stalled: a byte is held in the input register,
// then the parse state machine updates and any event lands in the result register.
// A byte is registered in the input register and its event in the result
// register, where the sink can take it.
// Synchronous reset returns the parser to seeking a marker prefix, zeroes the
// byte count and empties both registers.
// A stalled event holds the input register; a new byte is still taken in the
// cycle the held one moves on.
module jpeg_marker_segment_scanner_core #(
   parameter int OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   jmss_req_if.sink    req_if,
   jmss_rsp_if.source  rsp_if
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       advance, accept, out_valid;

   jmss_pkg::event_type ev, ev_q;

   assign advance      = in_valid_ff && (!out_valid || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   jmss_fsm #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .data_byte (in_byte_ff),
      .event_out (ev)
   );

   jmss_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .event_in (ev),
      .take     (rsp_if.ready),
      .valid    (out_valid),
      .event_q  (ev_q)
   );

   assign rsp_if.valid       = out_valid;
   assign rsp_if.event_kind  = ev_q.kind;
   assign rsp_if.marker_code = ev_q.code;
   assign rsp_if.byte_offset = ev_q.offset;

endmodule

FILE: sv/jmss_checker.sv
// Port-level checks of the scanner, bound to the top level.
`include "jpeg_marker_segment_scanner_core_assert.svh"

module jmss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_kind,
   input logic [7:0]  rsp_marker_code,
   input logic [31:0] rsp_byte_offset
);

   `JMSS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "event valid after reset")

   `JMSS_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_marker_code) && $stable(rsp_byte_offset), "stalled event changed")

   `JMSS_ASSERT_SAME(a_eoi_code, rsp_valid && (rsp_event_kind == jmss_pkg::EV_EOI), rsp_marker_code == jmss_pkg::EOI_CODE, "end of image with wrong code")

   `JMSS_ASSERT_SAME(a_scan_code, rsp_valid && (rsp_event_kind == jmss_pkg::EV_SCAN), rsp_marker_code == jmss_pkg::SOS_CODE, "start of scan with wrong code")

   `JMSS_ASSERT_SAME(a_segment_code, rsp_valid && (rsp_event_kind == jmss_pkg::EV_SEGMENT), (rsp_marker_code >= jmss_pkg::MARKER_LO) && (rsp_marker_code != jmss_pkg::PREFIX_BYTE) && (rsp_marker_code != jmss_pkg::SOS_CODE) && ((rsp_marker_code < jmss_pkg::STANDALONE_LO) || (rsp_marker_code > jmss_pkg::STANDALONE_HI)), "segment event with non-marker code")

endmodule

bind jpeg_marker_segment_scanner_core jmss_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_event_kind  (rsp_if.event_kind),
   .rsp_marker_code (rsp_if.marker_code),
   .rsp_byte_offset (rsp_if.byte_offset)
);

FILE: verif/tb_jpeg_marker_segment_scanner_core.sv
`timescale 1ns / 100ps
// Testbench for the JPEG marker segment scanner: byte streams in, marker reports checked.
module tb_jpeg_marker_segment_scanner_core;

   localparam logic [7:0] SOI_CODE = 8'hD8;

   typedef struct packed {
      jmss_pkg::event_kind_type kind;
      logic [7:0]               code;
      logic [31:0]              offset;
   } marker_report_type;

   logic clock;
   logic reset;

   jmss_req_if req_if();
   jmss_rsp_if rsp_if();

   jpeg_marker_segment_scanner_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [7:0]        pending_bytes[$];
   marker_report_type expected_reports[$];
   int unsigned       send_idle_pct = 35;
   int unsigned       recv_idle_pct = 71;
   int unsigned       queued = 0;
   int unsigned       bytes_accepted = 0;
   int unsigned       reports_checked = 0;
   int unsigned       kind_count[4] = '{default: 0};
   int unsigned       error_count = 0;

   // shadow of the parser
   jmss_pkg::parse_state_type walk_state;
   logic [7:0]                len_high;
   logic [15:0]               skip_left;
   logic [31:0]               byte_count;
   logic                      desync_seen;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("ERROR: %s", msg);
   endtask

   function automatic logic is_standalone(input logic [7:0] b);
      return b >= jmss_pkg::STANDALONE_LO && b <= jmss_pkg::STANDALONE_HI;
   endfunction

   task automatic note_report(input jmss_pkg::event_kind_type kind,
                              input logic [7:0] code, input logic [31:0] offset);
      marker_report_type rpt;
      rpt.kind   = kind;
      rpt.code   = code;
      rpt.offset = offset;
      expected_reports.push_back(rpt);
   endtask

   task automatic open_segment(input logic [7:0] code, input logic [31:0] pos);
      if (code == jmss_pkg::SOS_CODE) begin
         walk_state = jmss_pkg::ST_SCAN;
         note_report(jmss_pkg::EV_SCAN, code, pos);
      end else begin
         walk_state = jmss_pkg::ST_LEN_HI;
         note_report(jmss_pkg::EV_SEGMENT, code, pos);
      end
   endtask

   task automatic walk_byte(input logic [7:0] b);
      logic [31:0] pos;
      logic [15:0] seg_len;
      pos = byte_count;
      if (byte_count != '1)
         byte_count = byte_count + 32'd1;
      case (walk_state)
         jmss_pkg::ST_SEEK: begin
            if (b == jmss_pkg::PREFIX_BYTE) begin
               desync_seen = 1'b0;
               walk_state  = jmss_pkg::ST_PREFIX;
            end else if (!desync_seen) begin
               desync_seen = 1'b1;
               note_report(jmss_pkg::EV_DESYNC, b, pos);
            end
         end
         jmss_pkg::ST_PREFIX: begin
            if (b == jmss_pkg::PREFIX_BYTE) begin
               // fill byte: keep waiting for the code
            end else if (is_standalone(b))
               walk_state = jmss_pkg::ST_SEEK;
            else if (b >= jmss_pkg::MARKER_LO)
               open_segment(b, pos);
            else begin
               desync_seen = 1'b1;
               walk_state  = jmss_pkg::ST_SEEK;
               note_report(jmss_pkg::EV_DESYNC, b, pos);
            end
         end
         jmss_pkg::ST_LEN_HI: begin
            len_high   = b;
            walk_state = jmss_pkg::ST_LEN_LO;
         end
         jmss_pkg::ST_LEN_LO: begin
            seg_len    = {len_high, b};
            skip_left  = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
            walk_state = (skip_left != 16'd0) ? jmss_pkg::ST_SKIP : jmss_pkg::ST_SEEK;
         end
         jmss_pkg::ST_SKIP: begin
            if (skip_left != 16'd0)
               skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0)
               walk_state = jmss_pkg::ST_SEEK;
         end
         jmss_pkg::ST_SCAN: begin
            if (b == jmss_pkg::PREFIX_BYTE)
               walk_state = jmss_pkg::ST_SCAN_FF;
         end
         jmss_pkg::ST_SCAN_FF: begin
            if (b == jmss_pkg::PREFIX_BYTE) begin
               // fill inside scan data
            end else if (b == jmss_pkg::EOI_CODE) begin
               walk_state = jmss_pkg::ST_SEEK;
               // end of image carries the count including this byte
               note_report(jmss_pkg::EV_EOI, b, byte_count);
            end else if (b >= jmss_pkg::MARKER_LO && !is_standalone(b))
               open_segment(b, pos);
            else
               walk_state = jmss_pkg::ST_SCAN;
         end
         default: walk_state = jmss_pkg::ST_SEEK;
      endcase
   endtask

   // ---------------- stimulus builders ----------------

   task automatic put(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued++;
   endtask

   function automatic logic [7:0] pick_marker();
      logic [7:0] m;
      do
         m = 8'($urandom_range(8'hFE, 8'hC0));
      while (is_standalone(m) || m == jmss_pkg::SOS_CODE);
      return m;
   endfunction

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(31);
      if (r < 2)
         return $urandom_range(1);
      if (r == 2)
         return $urandom_range(280, 256);
      return $urandom_range(12, 2);
   endfunction

   task automatic put_segment(input logic [7:0] code, input int unsigned seg_len);
      if ($urandom_range(7) == 0)
         put(jmss_pkg::PREFIX_BYTE);
      put(jmss_pkg::PREFIX_BYTE);
      put(code);
      put(seg_len[15:8]);
      put(seg_len[7:0]);
      for (int i = 2; i < seg_len; i++)
         put(8'($urandom_range(255)));
   endtask

   // SOS followed by entropy data; stuffed, restart, fill and odd escapes mixed in
   task automatic put_scan();
      int unsigned n;
      n = $urandom_range(20, 3);
      put(jmss_pkg::PREFIX_BYTE);
      put(jmss_pkg::SOS_CODE);
      repeat (n) begin
         case ($urandom_range(7))
            0: begin
               put(jmss_pkg::PREFIX_BYTE);
               put(8'h00);
            end
            1: begin
               put(jmss_pkg::PREFIX_BYTE);
               put(8'($urandom_range(SOI_CODE, jmss_pkg::STANDALONE_LO)));
            end
            2: begin
               put(jmss_pkg::PREFIX_BYTE);
               put(jmss_pkg::PREFIX_BYTE);
               put(8'h00);
            end
            3: begin
               put(jmss_pkg::PREFIX_BYTE);
               put(8'($urandom_range(8'hBF, 8'h01)));
            end
            default: put(8'($urandom_range(8'hFE)));
         endcase
      end
   endtask

   task automatic put_image();
      int unsigned scans;
      put(jmss_pkg::PREFIX_BYTE);
      put(SOI_CODE);
      repeat ($urandom_range(3, 1))
         put_segment(pick_marker(), pick_len());
      scans = $urandom_range(2, 1);
      for (int s = 0; s < scans; s++) begin
         // a table segment between scans ends the previous one
         if (s != 0)
            put_segment(pick_marker(), pick_len());
         put_scan();
      end
      put(jmss_pkg::PREFIX_BYTE);
      put(jmss_pkg::EOI_CODE);
   endtask

   // broken input; stray bytes hold no 0xFF so no marker swallows what follows
   task automatic put_noise();
      case ($urandom_range(3))
         0: repeat ($urandom_range(6, 1))
               put(8'($urandom_range(8'hFE)));
         1: begin
            put(jmss_pkg::PREFIX_BYTE);
            put(8'($urandom_range(8'hBF)));
         end
         2: put_scan();
         default: begin
            put(jmss_pkg::PREFIX_BYTE);
            put(8'($urandom_range(jmss_pkg::STANDALONE_HI, jmss_pkg::STANDALONE_LO)));
         end
      endcase
   endtask

   task automatic queue_random(input int unsigned budget);
      int unsigned stop_at;
      stop_at = queued + budget;
      while (queued < stop_at) begin
         if ($urandom_range(4) == 0)
            put_noise();
         else
            put_image();
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.data_byte <= '0;
         rsp_if.ready     <= 1'b0;
      end else begin
         // advance only once the held item has gone
         if (!req_if.valid || req_if.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid     <= 1'b1;
               req_if.data_byte <= pending_bytes.pop_front();
            end else
               req_if.valid <= 1'b0;
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------- monitor: check reports, then track the accepted byte ----------------

   always @(posedge clock) begin
      marker_report_type want;
      if (reset) begin
         walk_state  = jmss_pkg::ST_SEEK;
         len_high    = '0;
         skip_left   = '0;
         byte_count  = '0;
         desync_seen = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            reports_checked++;
            if (expected_reports.size() == 0)
               flag_error($sformatf("unexpected report kind %0d code %02h offset %0d",
                                    rsp_if.event_kind, rsp_if.marker_code,
                                    rsp_if.byte_offset));
            else begin
               want = expected_reports.pop_front();
               kind_count[want.kind]++;
               if (rsp_if.event_kind !== want.kind || rsp_if.marker_code !== want.code ||
                   rsp_if.byte_offset !== want.offset)
                  flag_error($sformatf({"report mismatch: expected kind %0d code %02h ",
                                        "offset %0d, got kind %0d code %02h offset %0d"},
                                       want.kind, want.code, want.offset,
                                       rsp_if.event_kind, rsp_if.marker_code,
                                       rsp_if.byte_offset));
            end
         end
         if (req_if.valid && req_if.ready) begin
            bytes_accepted++;
            walk_byte(req_if.data_byte);
         end
      end
   end

   // ---------------- run control ----------------

   initial begin
      int unsigned       waited;
      marker_report_type left;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      rsp_if.ready     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // stray bytes: first reports desync, second is dropped
      put(8'h00);
      put(8'h12);
      // start of image is standalone and silent
      put(jmss_pkg::PREFIX_BYTE); put(SOI_CODE);
      // fill byte, then a segment whose length is below two
      put(jmss_pkg::PREFIX_BYTE); put(jmss_pkg::PREFIX_BYTE);
      put(8'hC0); put(8'h00); put(8'h01);
      // prefix followed by a non-marker byte
      put(jmss_pkg::PREFIX_BYTE); put(8'h00);
      // scan with stuffed, restart, odd, SOI and fill escapes, ended by end of image
      put(jmss_pkg::PREFIX_BYTE); put(jmss_pkg::SOS_CODE);
      put(jmss_pkg::PREFIX_BYTE); put(8'h00);
      put(jmss_pkg::PREFIX_BYTE); put(8'hD3);
      put(jmss_pkg::PREFIX_BYTE); put(8'h05);
      put(jmss_pkg::PREFIX_BYTE); put(SOI_CODE);
      put(jmss_pkg::PREFIX_BYTE); put(jmss_pkg::PREFIX_BYTE); put(jmss_pkg::EOI_CODE);
      // top marker code with one payload byte of all ones
      put(jmss_pkg::PREFIX_BYTE); put(8'hFE); put(8'h00); put(8'h03);
      put(jmss_pkg::PREFIX_BYTE);
      // scan ended straight away by another marker
      put(jmss_pkg::PREFIX_BYTE); put(jmss_pkg::SOS_CODE);
      put(jmss_pkg::PREFIX_BYTE); put(8'hC4); put(8'h00); put(8'h02);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         queue_random(180);
         while (pending_bytes.size() != 0)
            @(posedge clock);
      end

      while (pending_bytes.size() != 0 || req_if.valid)
         @(posedge clock);
      waited = 0;
      while (expected_reports.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      while (expected_reports.size() != 0) begin
         left = expected_reports.pop_front();
         flag_error($sformatf("missing report kind %0d code %02h offset %0d",
                              left.kind, left.code, left.offset));
      end

      $display("Walked %0d bytes of images, segments, scans and broken input",
               bytes_accepted);
      $display("Checked %0d reports: %0d segment, %0d scan, %0d end of image, %0d desync",
               reports_checked, kind_count[jmss_pkg::EV_SEGMENT],
               kind_count[jmss_pkg::EV_SCAN], kind_count[jmss_pkg::EV_EOI],
               kind_count[jmss_pkg::EV_DESYNC]);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5ms;
      $display("Run timed out");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/jmss_pkg.sv
sv/jmss_if.sv
sv/jmss_fsm.sv
sv/jmss_out_reg.sv
sv/jpeg_marker_segment_scanner_core.sv
sv/jmss_checker.sv
verif/tb_jpeg_marker_segment_scanner_core.sv
